FILE: rtl/ecbm_pkg.sv
// ----------------------------------------------------------------------------
// ecbm_pkg
// shared types and constants of the eye closure and blink monitor
// ----------------------------------------------------------------------------
package ecbm_pkg;

   localparam int unsigned COUNT_WIDTH_DEF = 16;
   localparam int unsigned ADDR_WIDTH      = 5;
   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned RUN_WIDTH       = 16;
   localparam int unsigned WIN_WIDTH       = 10;
   localparam int unsigned SUM_WIDTH       = 32;

   localparam logic [7:0]           DARK_LEVEL_RST    = 8'd15;
   localparam logic [RUN_WIDTH-1:0] CLOSED_LIMIT_RST  = 16'd70;
   localparam logic [RUN_WIDTH-1:0] CLOSURE_LIMIT_RST = 16'd20;
   localparam logic [WIN_WIDTH-1:0] WINDOW_FRAMES_RST = 10'd100;
   localparam logic [WIN_WIDTH-1:0] RATE_LIMIT_RST    = 10'd10;

   typedef enum logic [1:0] {
      ACT_PIXEL  = 2'd0,
      ACT_REGION = 2'd1,
      ACT_FRAME  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_DARK_LEVEL    = 3'd0,
      REG_CLOSED_LIMIT  = 3'd1,
      REG_CLOSURE_LIMIT = 3'd2,
      REG_WINDOW_FRAMES = 3'd3,
      REG_RATE_LIMIT    = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0]           dark_level;
      logic [RUN_WIDTH-1:0] closed_count_limit;
      logic [RUN_WIDTH-1:0] closure_frames_limit;
      logic [WIN_WIDTH-1:0] window_frames;
      logic [WIN_WIDTH-1:0] blink_rate_limit;
   } cfg_type;

   typedef struct packed {
      logic                 report_kind;
      logic                 eyes_closed;
      logic                 long_closure;
      logic                 blink_start;
      logic [SUM_WIDTH-1:0] blink_total;
      logic                 window_done;
      logic                 high_blink_rate;
      logic [WIN_WIDTH-1:0] window_blinks;
   } result_type;

endpackage

FILE: rtl/eye_closure_blink_monitor_unit.sv
// the result of an accepted region end or frame end item is registered in the result register, or in the skid
// entry while the result register is held; one item per cycle while req_stall is low; pixel items give no result
// a two-entry output stage (result register plus skid) keeps the input open while a
// result waits; req_stall rises only when both entries are full
// synchronous active-high reset clears all counters, flags and the valid bits of both output entries
// ----------------------------------------------------------------------------
// eye_closure_blink_monitor_unit
// dark pixel counting per eye region, closure and blink tracking, blink windows
// ----------------------------------------------------------------------------
module eye_closure_blink_monitor_unit
   import ecbm_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_pixel,
   input  logic                  req_border,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_report_kind,
   output logic                  rsp_eyes_closed,
   output logic                  rsp_long_closure,
   output logic                  rsp_blink_start,
   output logic [SUM_WIDTH-1:0]  rsp_blink_total,
   output logic                  rsp_window_done,
   output logic                  rsp_high_blink_rate,
   output logic [WIN_WIDTH-1:0]  rsp_window_blinks,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready
);

   localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > RUN_WIDTH) ? COUNT_WIDTH : RUN_WIDTH;

   cfg_type cfg;

   logic [COUNT_WIDTH-1:0] dark_count_ff, dark_count_in;
   logic [RUN_WIDTH-1:0]   closed_run_ff, closed_run_in;
   logic                   eye_closed_ff, eye_closed_in;
   logic                   blink_mark_ff, blink_mark_in;
   logic [SUM_WIDTH-1:0]   blink_sum_ff, blink_sum_in;
   logic [WIN_WIDTH-1:0]   win_pos_ff, win_pos_in;
   logic [WIN_WIDTH-1:0]   win_count_ff, win_count_in;

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   result_type           res;
   logic                 res_valid;
   logic                 accept;
   logic                 out_take;
   action_type           act;
   logic                 closed;
   logic [WIN_WIDTH-1:0] win_len;

   ecbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign act       = action_type'(req_action);

   assign closed  = CMP_WIDTH'(dark_count_ff) < CMP_WIDTH'(cfg.closed_count_limit);
   assign win_len = (cfg.window_frames == '0) ? WIN_WIDTH'(1) : cfg.window_frames;

   // per-item state update and result
   always_comb begin
      dark_count_in = dark_count_ff;
      closed_run_in = closed_run_ff;
      eye_closed_in = eye_closed_ff;
      blink_mark_in = blink_mark_ff;
      blink_sum_in  = blink_sum_ff;
      win_pos_in    = win_pos_ff;
      win_count_in  = win_count_ff;
      res           = '0;
      res_valid     = 1'b0;
      unique case (act)
         ACT_PIXEL: begin
            if (!req_border && (req_pixel <= cfg.dark_level) && (dark_count_ff != '1)) begin
               dark_count_in = dark_count_ff + COUNT_WIDTH'(1);
            end
         end
         ACT_REGION: begin
            dark_count_in = '0;
            res_valid     = 1'b1;
            if (closed) begin
               if (closed_run_ff != '1) begin
                  closed_run_in = closed_run_ff + RUN_WIDTH'(1);
               end
               if (!eye_closed_ff) begin
                  res.blink_start = 1'b1;
                  blink_mark_in   = 1'b1;
                  eye_closed_in   = 1'b1;
                  if (blink_sum_ff != '1) begin
                     blink_sum_in = blink_sum_ff + SUM_WIDTH'(1);
                  end
               end
            end else begin
               closed_run_in = '0;
               eye_closed_in = 1'b0;
            end
            res.eyes_closed  = closed;
            res.long_closure = closed_run_in > cfg.closure_frames_limit;
            res.blink_total  = blink_sum_in;
         end
         ACT_FRAME: begin
            dark_count_in = '0;
            res_valid     = 1'b1;
            if (blink_mark_ff && (win_count_ff != '1)) begin
               win_count_in = win_count_ff + WIN_WIDTH'(1);
            end
            blink_mark_in = 1'b0;
            if (win_pos_ff != '1) begin
               win_pos_in = win_pos_ff + WIN_WIDTH'(1);
            end
            res.report_kind = 1'b1;
            res.blink_total = blink_sum_ff;
            if (win_pos_in >= win_len) begin
               res.window_done     = 1'b1;
               res.high_blink_rate = win_count_in > cfg.blink_rate_limit;
               res.window_blinks   = win_count_in;
               win_count_in        = '0;
               win_pos_in          = '0;
            end
         end
         ACT_NONE: begin
         end
      endcase
   end

   // result register and skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_count_ff <= '0;
         closed_run_ff <= '0;
         eye_closed_ff <= 1'b0;
         blink_mark_ff <= 1'b0;
         blink_sum_ff  <= '0;
         win_pos_ff    <= '0;
         win_count_ff  <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            dark_count_ff <= dark_count_in;
            closed_run_ff <= closed_run_in;
            eye_closed_ff <= eye_closed_in;
            blink_mark_ff <= blink_mark_in;
            blink_sum_ff  <= blink_sum_in;
            win_pos_ff    <= win_pos_in;
            win_count_ff  <= win_count_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_report_kind     = out_ff.report_kind;
   assign rsp_eyes_closed     = out_ff.eyes_closed;
   assign rsp_long_closure    = out_ff.long_closure;
   assign rsp_blink_start     = out_ff.blink_start;
   assign rsp_blink_total     = out_ff.blink_total;
   assign rsp_window_done     = out_ff.window_done;
   assign rsp_high_blink_rate = out_ff.high_blink_rate;
   assign rsp_window_blinks   = out_ff.window_blinks;

endmodule

FILE: rtl/ecbm_csr.sv
// ----------------------------------------------------------------------------
// ecbm_csr
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module ecbm_csr
   import ecbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   output logic [DATA_WIDTH-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[ADDR_WIDTH-1:2]);
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_level           <= DARK_LEVEL_RST;
         cfg_ff.closed_count_limit   <= CLOSED_LIMIT_RST;
         cfg_ff.closure_frames_limit <= CLOSURE_LIMIT_RST;
         cfg_ff.window_frames        <= WINDOW_FRAMES_RST;
         cfg_ff.blink_rate_limit     <= RATE_LIMIT_RST;
      end else if (wr_en) begin
         case (idx)
            REG_DARK_LEVEL:    cfg_ff.dark_level           <= pwdata[7:0];
            REG_CLOSED_LIMIT:  cfg_ff.closed_count_limit   <= pwdata[RUN_WIDTH-1:0];
            REG_CLOSURE_LIMIT: cfg_ff.closure_frames_limit <= pwdata[RUN_WIDTH-1:0];
            REG_WINDOW_FRAMES: cfg_ff.window_frames        <= pwdata[WIN_WIDTH-1:0];
            REG_RATE_LIMIT:    cfg_ff.blink_rate_limit     <= pwdata[WIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (idx)
         REG_DARK_LEVEL:    prdata = DATA_WIDTH'(cfg_ff.dark_level);
         REG_CLOSED_LIMIT:  prdata = DATA_WIDTH'(cfg_ff.closed_count_limit);
         REG_CLOSURE_LIMIT: prdata = DATA_WIDTH'(cfg_ff.closure_frames_limit);
         REG_WINDOW_FRAMES: prdata = DATA_WIDTH'(cfg_ff.window_frames);
         REG_RATE_LIMIT:    prdata = DATA_WIDTH'(cfg_ff.blink_rate_limit);
         default:           prdata = '0;
      endcase
   end

endmodule

FILE: tb/blink_monitor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blink_monitor_checker
// watches the item, result and register ports of the blink monitor, keeps its
// own copy of the counters and settings, predicts each report and compares it
// field by field with what the block hands out
// ----------------------------------------------------------------------------
module blink_monitor_checker
   import ecbm_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_pixel,
   input  logic                  req_border,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_report_kind,
   input  logic                  rsp_eyes_closed,
   input  logic                  rsp_long_closure,
   input  logic                  rsp_blink_start,
   input  logic [SUM_WIDTH-1:0]  rsp_blink_total,
   input  logic                  rsp_window_done,
   input  logic                  rsp_high_blink_rate,
   input  logic [WIN_WIDTH-1:0]  rsp_window_blinks,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_WIDTH-1:0] paddr,
   input  logic [DATA_WIDTH-1:0] pwdata,
   input  logic                  pready,
   output int                    mismatch_count,
   output int                    reports_pending
);

   cfg_type                cfg;
   logic [COUNT_WIDTH-1:0] dark_count;
   logic [RUN_WIDTH-1:0]   closed_run;
   logic                   eye_is_closed;
   logic                   frame_blink_mark;
   logic [SUM_WIDTH-1:0]   blink_sum;
   logic [WIN_WIDTH-1:0]   window_position;
   logic [WIN_WIDTH-1:0]   window_count;
   result_type             reports_due[$];
   int                     mismatches = 0;
   int                     queue_depth = 0;

   assign mismatch_count  = mismatches;
   assign reports_pending = queue_depth;

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s is %0h, %0h due", name, got, want));
      end
   endtask

   // advances the monitor state by one item, returns 1 with the report it causes
   function automatic bit eye_report(input action_type act, input logic [7:0] pix,
                                     input logic brd, output result_type rep);
      logic                 closed;
      logic [WIN_WIDTH-1:0] span;
      rep = '0;
      eye_report = 1'b0;
      span = (cfg.window_frames == '0) ? WIN_WIDTH'(1) : cfg.window_frames;
      case (act)
         ACT_PIXEL: begin
            if (!brd && pix <= cfg.dark_level && dark_count != '1) begin
               dark_count = dark_count + COUNT_WIDTH'(1);
            end
         end
         ACT_REGION: begin
            closed = (dark_count < cfg.closed_count_limit);
            dark_count = '0;
            rep.eyes_closed = closed;
            if (closed) begin
               if (closed_run != '1) begin
                  closed_run = closed_run + RUN_WIDTH'(1);
               end
               if (!eye_is_closed) begin
                  rep.blink_start = 1'b1;
                  if (blink_sum != '1) begin
                     blink_sum = blink_sum + SUM_WIDTH'(1);
                  end
                  frame_blink_mark = 1'b1;
                  eye_is_closed = 1'b1;
               end
            end else begin
               closed_run = '0;
               eye_is_closed = 1'b0;
            end
            rep.long_closure = (closed_run > cfg.closure_frames_limit);
            rep.blink_total = blink_sum;
            eye_report = 1'b1;
         end
         ACT_FRAME: begin
            dark_count = '0;
            if (frame_blink_mark && window_count != '1) begin
               window_count = window_count + WIN_WIDTH'(1);
            end
            frame_blink_mark = 1'b0;
            if (window_position != '1) begin
               window_position = window_position + WIN_WIDTH'(1);
            end
            rep.report_kind = 1'b1;
            rep.blink_total = blink_sum;
            if (window_position >= span) begin
               rep.window_done = 1'b1;
               rep.high_blink_rate = (window_count > cfg.blink_rate_limit);
               rep.window_blinks = window_count;
               window_count = '0;
               window_position = '0;
            end
            eye_report = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      result_type fresh;
      if (reset) begin
         cfg.dark_level = DARK_LEVEL_RST;
         cfg.closed_count_limit = CLOSED_LIMIT_RST;
         cfg.closure_frames_limit = CLOSURE_LIMIT_RST;
         cfg.window_frames = WINDOW_FRAMES_RST;
         cfg.blink_rate_limit = RATE_LIMIT_RST;
         dark_count = '0;
         closed_run = '0;
         eye_is_closed = 1'b0;
         frame_blink_mark = 1'b0;
         blink_sum = '0;
         window_position = '0;
         window_count = '0;
         reports_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_WIDTH-1:2])
               REG_DARK_LEVEL:    cfg.dark_level = pwdata[7:0];
               REG_CLOSED_LIMIT:  cfg.closed_count_limit = pwdata[RUN_WIDTH-1:0];
               REG_CLOSURE_LIMIT: cfg.closure_frames_limit = pwdata[RUN_WIDTH-1:0];
               REG_WINDOW_FRAMES: cfg.window_frames = pwdata[WIN_WIDTH-1:0];
               REG_RATE_LIMIT:    cfg.blink_rate_limit = pwdata[WIN_WIDTH-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               flag_mismatch("report with none due");
            end else begin
               want = reports_due.pop_front();
               check_field("report_kind", 32'(rsp_report_kind), 32'(want.report_kind));
               check_field("eyes_closed", 32'(rsp_eyes_closed), 32'(want.eyes_closed));
               check_field("long_closure", 32'(rsp_long_closure), 32'(want.long_closure));
               check_field("blink_start", 32'(rsp_blink_start), 32'(want.blink_start));
               check_field("blink_total", rsp_blink_total, want.blink_total);
               check_field("window_done", 32'(rsp_window_done), 32'(want.window_done));
               check_field("high_blink_rate", 32'(rsp_high_blink_rate),
                           32'(want.high_blink_rate));
               check_field("window_blinks", 32'(rsp_window_blinks),
                           32'(want.window_blinks));
            end
         end
         if (req_valid && !req_stall) begin
            if (eye_report(action_type'(req_action), req_pixel, req_border, fresh)) begin
               reports_due.push_back(fresh);
            end
         end
      end
      queue_depth = reports_due.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives pixel, region end and frame end items into the blink monitor under
// several register settings, with random gaps on the sender and stalls on the
// receiver; the checker beside the block predicts every report
// ----------------------------------------------------------------------------
module tb_top;
   import ecbm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = ACT_PIXEL;
   logic [7:0]            req_pixel = 8'd0;
   logic                  req_border = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_report_kind;
   logic                  rsp_eyes_closed;
   logic                  rsp_long_closure;
   logic                  rsp_blink_start;
   logic [SUM_WIDTH-1:0]  rsp_blink_total;
   logic                  rsp_window_done;
   logic                  rsp_high_blink_rate;
   logic [WIN_WIDTH-1:0]  rsp_window_blinks;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0] pwdata = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    reports_pending;

   int                    cycle_count = 0;
   bit                    pace_on = 1'b1;
   int                    burst_left = 0;
   int                    stall_mode = 0;
   int                    stall_left = 0;
   int                    items_sent = 0;
   int                    pixel_span = 8;
   logic [7:0]            dark_level_now = DARK_LEVEL_RST;

   eye_closure_blink_monitor_unit i_dut (.*);

   blink_monitor_checker i_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver stalls in stretches: none, light, heavy or periodic
   always @(posedge clock) begin
      if (reset || !pace_on) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 64);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (cycle_count % 3 == 0);
         endcase
      end
   end

   task automatic send_item(input action_type act, input logic [7:0] pix, input logic brd);
      int gap;
      if (pace_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel <= pix;
      req_border <= brd;
      do @(posedge clock); while (req_stall);
      if (act != ACT_NONE) begin
         items_sent++;
      end
   endtask

   // pixel values cluster round the dark level half of the time
   task automatic send_pixel();
      int level;
      level = int'(dark_level_now) + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 0 || level < 0 || level > 255) begin
         level = $urandom_range(0, 255);
      end
      send_item(ACT_PIXEL, level[7:0], $urandom_range(0, 3) == 0);
   endtask

   // mostly well-formed frames, some with an unterminated region, stray pixels or noise
   task automatic send_frame();
      int regions;
      int shape;
      regions = $urandom_range(0, 2);
      shape = $urandom_range(0, 9);
      for (int r = 0; r < regions; r++) begin
         repeat ($urandom_range(0, pixel_span)) send_pixel();
         if (!(shape == 0 && r == regions - 1)) begin
            send_item(ACT_REGION, 8'($urandom), 1'($urandom));
         end
      end
      if (shape == 1) begin
         send_item(ACT_NONE, 8'($urandom), 1'($urandom));
      end
      if (shape == 2) begin
         repeat ($urandom_range(1, 4)) send_pixel();
      end
      send_item(ACT_FRAME, 8'($urandom), 1'($urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DATA_WIDTH-1:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_WIDTH-1:0] noise_above(input int width);
      noise_above = ($urandom_range(0, 1) == 0) ? '0 : ($urandom << width);
   endfunction

   task automatic apply_config(input logic [7:0] dl, input logic [RUN_WIDTH-1:0] ccl,
                               input logic [RUN_WIDTH-1:0] cfl,
                               input logic [WIN_WIDTH-1:0] wf,
                               input logic [WIN_WIDTH-1:0] brl);
      dark_level_now = dl;
      csr_write(REG_DARK_LEVEL, noise_above(8) | DATA_WIDTH'(dl));
      csr_write(REG_CLOSED_LIMIT, noise_above(RUN_WIDTH) | DATA_WIDTH'(ccl));
      csr_write(REG_CLOSURE_LIMIT, noise_above(RUN_WIDTH) | DATA_WIDTH'(cfl));
      csr_write(REG_WINDOW_FRAMES, noise_above(WIN_WIDTH) | DATA_WIDTH'(wf));
      csr_write(REG_RATE_LIMIT, noise_above(WIN_WIDTH) | DATA_WIDTH'(brl));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: dark at and below 15, border pixels skipped
      send_item(ACT_PIXEL, 8'd0, 1'b0);
      send_item(ACT_PIXEL, 8'd15, 1'b0);
      send_item(ACT_PIXEL, 8'd16, 1'b0);
      send_item(ACT_PIXEL, 8'd0, 1'b1);
      send_item(ACT_PIXEL, 8'd255, 1'b1);
      send_item(ACT_PIXEL, 8'd255, 1'b0);
      send_item(ACT_NONE, 8'd255, 1'b1);
      send_item(ACT_REGION, 8'd0, 1'b0);
      send_item(ACT_REGION, 8'd255, 1'b1);
      send_item(ACT_FRAME, 8'd0, 1'b0);
      send_item(ACT_FRAME, 8'd255, 1'b1);
      send_item(ACT_PIXEL, 8'd0, 1'b0);
      send_item(ACT_PIXEL, 8'd3, 1'b0);
      send_item(ACT_FRAME, 8'd0, 1'b0);
      send_item(ACT_REGION, 8'd0, 1'b0);
      send_item(ACT_FRAME, 8'd0, 1'b0);
      settle();

      // lowest settings, zero window length
      apply_config(8'd0, 16'd0, 16'd0, 10'd0, 10'd0);
      while (items_sent < 116) send_frame();
      settle();

      // long window with a blink in every frame
      apply_config(8'd255, 16'd1, 16'hFFFF, 10'd40, 10'd39);
      repeat (44) begin
         send_item(ACT_REGION, 8'($urandom), 1'($urandom));
         send_item(ACT_PIXEL, 8'($urandom), 1'b0);
         send_item(ACT_REGION, 8'($urandom), 1'($urandom));
         send_item(ACT_FRAME, 8'($urandom), 1'($urandom));
      end
      settle();

      // shrunk window, then a long open region and a run of closed regions
      apply_config(8'd255, 16'd24, 16'd8, 10'd2, 10'd1023);
      pace_on <= 1'b0;
      @(posedge clock);
      send_item(ACT_FRAME, 8'($urandom), 1'($urandom));
      repeat (30) send_item(ACT_PIXEL, 8'($urandom), 1'b0);
      send_item(ACT_REGION, 8'($urandom), 1'($urandom));
      repeat (10) send_item(ACT_REGION, 8'($urandom), 1'($urandom));
      send_item(ACT_FRAME, 8'($urandom), 1'($urandom));
      settle();
      pace_on <= 1'b1;
      @(posedge clock);

      repeat (4) begin
         pixel_span = $urandom_range(2, 30);
         apply_config(8'($urandom_range(0, 255)), RUN_WIDTH'($urandom_range(0, pixel_span)),
                      RUN_WIDTH'($urandom_range(0, 4)), WIN_WIDTH'($urandom_range(0, 7)),
                      WIN_WIDTH'($urandom_range(0, 3)));
         begin : random_phase
            int target;
            target = items_sent + 90;
            while (items_sent < target) send_frame();
         end
         settle();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ecbm_pkg.sv
rtl/ecbm_csr.sv
rtl/eye_closure_blink_monitor_unit.sv
tb/blink_monitor_checker.sv
tb/tb_top.sv
